// ----- sv/m4fm_pkg.sv -----
package m4fm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned Depth = 16;
  localparam int unsigned Dim   = 4;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned AccW  = ProdW + 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             load;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] left;
    logic [DataW-1:0] right;
  } cell_wr_t;

endpackage

// ----- sv/m4fm_cell.sv -----
module m4fm_cell
  import m4fm_pkg::*;
#(
  parameter logic [IdxW-1:0] CellIdx = '0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_wr_t                wr_i,
  input  logic                    shift_i,
  input  logic signed [DataW-1:0] chain_i,
  output logic signed [DataW-1:0] chain_o,
  output logic signed [DataW-1:0] left_o
);

  logic signed [DataW-1:0] left_q;
  logic signed [DataW-1:0] right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (wr_i.load && wr_i.idx == CellIdx) begin
      left_q  <= wr_i.left;
      right_q <= wr_i.right;
    end else if (shift_i) begin
      right_q <= chain_i;
    end
  end

  assign chain_o = right_q;
  assign left_o  = left_q;

endmodule

// ----- sv/m4fm_dot.sv -----
module m4fm_dot
  import m4fm_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                    clk_i,
  input  logic                    mul_i,
  input  logic                    sum_i,
  input  logic signed [DataW-1:0] a_i [Dim],
  input  logic signed [DataW-1:0] b_i [Dim],
  output logic signed [DataW-1:0] res_o
);

  logic signed [ProdW-1:0] prod_q [Dim];
  logic signed [AccW-1:0]  sum_w;
  logic signed [AccW-1:0]  sh_w;
  logic signed [DataW-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (mul_i) begin
      for (int k = 0; k < Dim; k++) begin
        prod_q[k] <= a_i[k] * b_i[k];
      end
    end
    if (sum_i) begin
      res_q <= (sh_w > AccW'(signed'({1'b0, {(DataW-1){1'b1}}}))) ?
               {1'b0, {(DataW-1){1'b1}}} :
               (sh_w < -AccW'(signed'({1'b0, 1'b1, {(DataW-1){1'b0}}}))) ?
               {1'b1, {(DataW-1){1'b0}}} : sh_w[DataW-1:0];
    end
  end

  always_comb begin
    sum_w = AccW'(prod_q[0]) + AccW'(prod_q[1]) + AccW'(prod_q[2])
          + AccW'(prod_q[3]);
    sh_w  = sum_w >>> FracBits;
  end

  assign res_o = res_q;

endmodule

// ----- sv/mat4_fixed_multiply_core.sv -----
// 4x4 column-major Q16.16 matrix product, c = a * b.
// input stream s_axis: each transaction carries index n with a[n] and b[n];
// the pair is stored in a row of sixteen cells. loads are accepted back to back.
// index 15 stores its pair and starts a product run; s_axis_tready stays
// low until all sixteen results have been taken.
// output stream m_axis: sixteen transactions in index order, tlast on the
// sixteenth. each result passes through ST_MUL (multiply four products),
// ST_SUM (sum, shift and saturate into the output register) and ST_OUT,
// where the output register waits for m_axis_tready. after each result
// column the cell chain rotates the b entries by four positions: each cell
// takes the b of the cell four places on, so the next b column is in place.
// a stalled receiver simply holds the output register; nothing is lost.
// reset clears the control state and the cells; entries must be written
// before a product is started.
module mat4_fixed_multiply_core
  import m4fm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // left_element, right_element
  input  logic [3:0]  s_axis_tuser,  // element_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // product_value
  output logic [3:0]  m_axis_tuser,  // product_index
  output logic        m_axis_tlast
);

  state_e state_q, state_d;
  logic [IdxW-1:0] oidx_q, oidx_d;
  logic [1:0] rot_q, rot_d;
  logic shift_w, mul_w, sum_w;
  logic s_fire, m_fire;
  cell_wr_t wr_w;
  logic signed [DataW-1:0] chain_w [Depth];
  logic signed [DataW-1:0] left_w  [Depth];
  logic signed [DataW-1:0] a_w [Dim];
  logic signed [DataW-1:0] b_w [Dim];
  logic signed [DataW-1:0] res_w;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    wr_w.load  = s_fire;
    wr_w.idx   = s_axis_tuser;
    wr_w.left  = s_axis_tdata[31:0];
    wr_w.right = s_axis_tdata[63:32];
  end

  for (genvar c = 0; c < Depth; c++) begin : g_cell
    m4fm_cell #(.CellIdx(IdxW'(c))) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (wr_w),
      .shift_i (shift_w),
      .chain_i (chain_w[(c + Dim) % Depth]),
      .chain_o (chain_w[c]),
      .left_o  (left_w[c])
    );
  end

  always_comb begin
    for (int k = 0; k < Dim; k++) begin
      a_w[k] = left_w[k * Dim + oidx_q[1:0]];
      b_w[k] = chain_w[k];
    end
  end

  m4fm_dot #(.FracBits(FRAC_BITS)) u_dot (
    .clk_i (clk_i),
    .mul_i (mul_w),
    .sum_i (sum_w),
    .a_i   (a_w),
    .b_i   (b_w),
    .res_o (res_w)
  );

  always_comb begin
    state_d = state_q;
    oidx_d  = oidx_q;
    rot_d   = rot_q;
    unique case (state_q)
      ST_LOAD: if (s_fire && s_axis_tuser == IdxW'(Depth - 1)) begin
        state_d = ST_MUL;
        oidx_d  = '0;
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) begin
        oidx_d = oidx_q + 1'b1;
        if (oidx_q == IdxW'(Depth - 1)) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_MUL;
        end
        if (oidx_q[1:0] == 2'd3) begin
          rot_d = rot_q + 1'b1;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_LOAD);
    mul_w         = (state_q == ST_MUL);
    sum_w         = (state_q == ST_SUM);
    m_axis_tvalid = (state_q == ST_OUT);
    shift_w       = m_fire && (oidx_q[1:0] == 2'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      oidx_q  <= '0;
      rot_q   <= '0;
    end else begin
      state_q <= state_d;
      oidx_q  <= oidx_d;
      rot_q   <= rot_d;
    end
  end

  assign m_axis_tdata = res_w;
  assign m_axis_tuser = oidx_q;
  assign m_axis_tlast = (oidx_q == IdxW'(Depth - 1));

`ifndef SYNTH
  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted during a product run");
  a_rot_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (rot_q == 2'd0))
    else $error("cell chain not back in place after a run");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser == 4'd15) |=> (state_q == ST_MUL && oidx_q == 4'd0))
    else $error("product run did not start");
`endif

endmodule
